FILE: src/gf128mu_pkg.sv
// Shared types, constants and the field doubling function for the GF(2^128) multiplier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package gf128mu_pkg;

    // Field and stream geometry
    localparam int FIELD_W     = 128;
    localparam int HALF_W      = 64;
    localparam int S_DATA_W    = 2 * FIELD_W;
    localparam int M_DATA_W    = FIELD_W;
    localparam int STEP_BITS   = 8;
    localparam int NUM_STAGES  = FIELD_W / STEP_BITS;

    // Low terms of x^128 + x^7 + x^2 + x + 1
    localparam logic [FIELD_W-1:0] REDUCE_POLY = FIELD_W'('h87);

    // One pipeline slot: running product, multiplicand and unconsumed multiplier bits
    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] acc;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
    } stage_t;

    // Multiply by x and reduce
    function automatic logic [FIELD_W-1:0] gf_dbl(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] shifted;
        shifted = {v[FIELD_W-2:0], 1'b0};
        return v[FIELD_W-1] ? (shifted ^ REDUCE_POLY) : shifted;
    endfunction

endpackage

FILE: src/gf128_multiplier_unit.sv
// GF(2^128) multiplier, polynomial x^128 + x^7 + x^2 + x + 1, as a 16-stage pipeline.
// An accepted input word moves through the stage registers in order to the result word; stalls hold it in place.
// Throughput: one word per cycle while not stalled; each stage folds 8 bits of b into the running product.
// All stages advance together; the pipeline stalls only while the last stage holds a
// result that is not taken. Reset (aresetn low, synchronous) clears all valid bits.
`timescale 1ns / 1ps

module gf128_multiplier_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata fields, low bit up: a_hi[63:0], a_lo[63:0], b_hi[63:0], b_lo[63:0]
    input  logic [gf128mu_pkg::S_DATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields, low bit up: prod_hi[63:0], prod_lo[63:0]
    output logic [gf128mu_pkg::M_DATA_W-1:0] m_tdata
);
    import gf128mu_pkg::*;

    stage_t chain [0:NUM_STAGES];
    logic   advance;

    // Advance whenever the output slot is empty or being drained
    assign advance  = !chain[NUM_STAGES].valid || m_tready;
    assign s_tready = advance;

    // Unpack the input word into the first slot
    assign chain[0].valid = s_tvalid;
    assign chain[0].acc   = '0;
    assign chain[0].a     = {s_tdata[HALF_W-1:0], s_tdata[2*HALF_W-1:HALF_W]};
    assign chain[0].b     = {s_tdata[3*HALF_W-1:2*HALF_W], s_tdata[4*HALF_W-1:3*HALF_W]};

    // Stage chain
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        gf128mu_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
    end

    // Pack the result word: prod_hi low, prod_lo high
    assign m_tvalid = chain[NUM_STAGES].valid;
    assign m_tdata  = {chain[NUM_STAGES].acc[HALF_W-1:0],
                       chain[NUM_STAGES].acc[FIELD_W-1:HALF_W]};

endmodule

FILE: src/gf128mu_stage.sv
// One pipeline stage of the GF(2^128) multiplier: consumes STEP_BITS bits of b, MSB first.
// Depends on gf128mu_pkg.
`timescale 1ns / 1ps

module gf128mu_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  gf128mu_pkg::stage_t  stage_in,
    output gf128mu_pkg::stage_t  stage_out
);
    import gf128mu_pkg::*;

    stage_t stage_reg;
    stage_t stage_next;

    // Horner steps: double the running value, then add a where the b bit is set
    always_comb begin
        logic [FIELD_W-1:0] acc;
        acc = stage_in.acc;
        for (int i = 0; i < STEP_BITS; i++) begin
            acc = gf_dbl(acc) ^ (stage_in.b[FIELD_W-1-i] ? stage_in.a : '0);
        end
        stage_next.valid = stage_in.valid;
        stage_next.acc   = acc;
        stage_next.a     = stage_in.a;
        stage_next.b     = {stage_in.b[FIELD_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
    end

    // Valid bit cleared by reset; payload not reset; hold everything on stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg.valid <= stage_next.valid;
        end
        if (advance) begin
            stage_reg.acc <= stage_next.acc;
            stage_reg.a   <= stage_next.a;
            stage_reg.b   <= stage_next.b;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: src/gf128mu_checker.sv
// Port-level checks for gf128_multiplier_unit, attached by bind.
// Depends on gf128mu_pkg for the stream widths.
`timescale 1ns / 1ps

module gf128mu_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [gf128mu_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [gf128mu_pkg::M_DATA_W-1:0] m_tdata
);
    import gf128mu_pkg::*;

    // A stalled result word holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed or dropped while stalled");

    // Input side is ready exactly when the output slot can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output slot");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        (!aresetn) |=> !m_tvalid)
        else $error("result word valid right after reset");

    // A refused input word holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
        else $error("input word changed or dropped while refused");

endmodule

bind gf128_multiplier_unit gf128mu_checker u_gf128mu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
